// ===== design/bfpu_pkg.sv =====
`default_nettype none

package bfpu_pkg;

  // Store geometry
  localparam int unsigned STORE_BYTES = 4096;
  localparam int unsigned TOTAL_BITS  = 8 * STORE_BYTES;
  localparam int unsigned ADDR_W      = $clog2(STORE_BYTES);
  localparam int unsigned POS_W       = ADDR_W + 3;
  // start + count must fit, and so must the store size in bits
  localparam int unsigned SUM_W       = (POS_W + 1 > 16) ? POS_W + 1 : 16;

  // Fixed field widths
  localparam int unsigned START_W = 15;
  localparam int unsigned COUNT_W = 7;
  localparam int unsigned VALUE_W = 64;

  localparam logic [COUNT_W-1:0] MAX_FIELD_BITS = COUNT_W'(64);

  typedef enum logic {
    KIND_PACK   = 1'b0,
    KIND_UNPACK = 1'b1
  } kind_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_LOAD,
    ST_BIT,
    ST_WRITE,
    ST_DONE
  } state_e;

  typedef struct packed {
    kind_e                kind;
    logic [START_W-1:0]   bit_start;
    logic [COUNT_W-1:0]   bit_count;
    logic [VALUE_W-1:0]   write_value;
  } in_t;

  typedef struct packed {
    logic [VALUE_W-1:0]   read_value;
    logic                 range_error;
  } out_t;

endpackage

`default_nettype wire

// ===== design/bfpu_ram.sv =====
`default_nettype none

// Single-port-write, single-port-read RAM with registered read data.
module bfpu_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 4096,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== design/bfpu_out_reg.sv =====
`default_nettype none

// One-entry output register between the engine and the output channel.
module bfpu_out_reg (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           res_valid_i,
  output logic                res_ready_o,
  input  wire bfpu_pkg::out_t res_word_i,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  output bfpu_pkg::out_t      out_word_o
);
  import bfpu_pkg::*;

  logic valid_q, valid_d;
  out_t word_q;

  assign res_ready_o = !valid_q || out_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (res_valid_i && res_ready_o) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid_i && res_ready_o) begin
      word_q <= res_word_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_word_o  = word_q;

endmodule

`default_nettype wire

// ===== design/bfpu_engine.sv =====
`default_nettype none

// Bit-serial field engine: clears the store after reset, then walks each
// field one bit per cycle between byte reads; pack writes each byte back.
module bfpu_engine (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output logic                              in_ready_o,
  input  wire bfpu_pkg::in_t                in_word_i,
  output logic                              res_valid_o,
  input  wire logic                         res_ready_i,
  output bfpu_pkg::out_t                    res_word_o,
  output logic                              ram_we_o,
  output logic [bfpu_pkg::ADDR_W-1:0]       ram_waddr_o,
  output logic [7:0]                        ram_wdata_o,
  output logic [bfpu_pkg::ADDR_W-1:0]       ram_raddr_o,
  input  wire logic [7:0]                   ram_rdata_i
);
  import bfpu_pkg::*;

  state_e               state_q, state_d;
  logic [POS_W-1:0]     pos_q, pos_d;
  logic [ADDR_W-1:0]    addr_q, addr_d;
  logic [ADDR_W-1:0]    clr_q, clr_d;
  logic [COUNT_W-1:0]   left_q, left_d;
  logic [VALUE_W-1:0]   sr_q, sr_d;
  logic [7:0]           byte_q, byte_d;
  kind_e                kind_q, kind_d;
  logic                 err_q, err_d;

  logic [SUM_W-1:0]     end_sum;
  logic                 overlong;
  logic                 past_end;
  logic                 no_op;
  logic [2:0]           bit_sel;
  logic                 byte_edge;

  // Range check on the incoming word
  assign end_sum  = SUM_W'(in_word_i.bit_start) + SUM_W'(in_word_i.bit_count);
  assign overlong = in_word_i.bit_count > MAX_FIELD_BITS;
  assign past_end = !overlong && (end_sum > SUM_W'(TOTAL_BITS));
  assign no_op    = overlong || past_end || (in_word_i.bit_count == '0);

  // MSB-first: bit position p lives at byte bit 7 - p[2:0]
  assign bit_sel   = ~pos_q[2:0];
  // pack walks downward, unpack upward
  assign byte_edge = (kind_q == KIND_PACK) ? (pos_q[2:0] == 3'd0) : (pos_q[2:0] == 3'd7);

  always_comb begin
    state_d     = state_q;
    pos_d       = pos_q;
    addr_d      = addr_q;
    clr_d       = clr_q;
    left_d      = left_q;
    sr_d        = sr_q;
    byte_d      = byte_q;
    kind_d      = kind_q;
    err_d       = err_q;
    in_ready_o  = 1'b0;
    res_valid_o = 1'b0;
    ram_we_o    = 1'b0;
    ram_waddr_o = addr_q;
    ram_wdata_o = byte_q;
    ram_raddr_o = pos_q[POS_W-1:3];

    case (state_q)
      ST_CLEAR: begin
        ram_we_o    = 1'b1;
        ram_waddr_o = clr_q;
        ram_wdata_o = '0;
        clr_d       = clr_q + 1'b1;
        if (clr_q == ADDR_W'(STORE_BYTES - 1)) begin
          state_d = ST_IDLE;
        end
      end

      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          kind_d = in_word_i.kind;
          err_d  = past_end;
          left_d = in_word_i.bit_count;
          if (no_op) begin
            sr_d    = '0;
            state_d = ST_DONE;
          end else if (in_word_i.kind == KIND_PACK) begin
            sr_d    = in_word_i.write_value;
            pos_d   = POS_W'(end_sum - SUM_W'(1));
            state_d = ST_READ;
          end else begin
            sr_d    = '0;
            pos_d   = POS_W'(in_word_i.bit_start);
            state_d = ST_READ;
          end
        end
      end

      ST_READ: begin
        addr_d  = pos_q[POS_W-1:3];
        state_d = ST_LOAD;
      end

      ST_LOAD: begin
        byte_d  = ram_rdata_i;
        state_d = ST_BIT;
      end

      ST_BIT: begin
        left_d = left_q - 1'b1;
        if (kind_q == KIND_PACK) begin
          byte_d          = byte_q;
          byte_d[bit_sel] = sr_q[0];
          sr_d            = {1'b0, sr_q[VALUE_W-1:1]};
          pos_d           = pos_q - 1'b1;
        end else begin
          sr_d  = {sr_q[VALUE_W-2:0], byte_q[bit_sel]};
          pos_d = pos_q + 1'b1;
        end
        if (left_q == COUNT_W'(1) || byte_edge) begin
          if (kind_q == KIND_PACK) begin
            state_d = ST_WRITE;
          end else if (left_q == COUNT_W'(1)) begin
            state_d = ST_DONE;
          end else begin
            state_d = ST_READ;
          end
        end
      end

      ST_WRITE: begin
        ram_we_o = 1'b1;
        state_d  = (left_q == '0) ? ST_DONE : ST_READ;
      end

      ST_DONE: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign res_word_o.read_value  = (kind_q == KIND_UNPACK) ? sr_q : '0;
  assign res_word_o.range_error = err_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clr_q   <= '0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q  <= pos_d;
    addr_q <= addr_d;
    left_q <= left_d;
    sr_q   <= sr_d;
    byte_q <= byte_d;
    kind_q <= kind_d;
    err_q  <= err_d;
  end

endmodule

`default_nettype wire

// ===== design/bit_field_pack_unpack.sv =====
// No-op words (bit_count 0 or above 64, or past the store end) skip the bit walk.
// Throughput: one word at a time; the bit-serial walk over the byte RAM sets it,
//   one field bit per cycle plus a read/load (and write on pack) per byte.
// Reset: rst_ni asynchronous, active low; a clearing pass over all STORE_BYTES
//   (4096) bytes zeroes the store, with in_ready_o low until it ends.
`default_nettype none

module bit_field_pack_unpack (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire bfpu_pkg::in_t in_word_i,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output bfpu_pkg::out_t     out_word_o
);
  import bfpu_pkg::*;

  // engine to output register
  logic              res_valid;
  logic              res_ready;
  out_t              res_word;

  // byte store port
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [7:0]        ram_wdata;
  logic [ADDR_W-1:0] ram_raddr;
  logic [7:0]        ram_rdata;

  // Sequencer: clear pass, then per-word bit walk; pack does byte read-modify-write
  bfpu_engine u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_word_i   (in_word_i),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_word_o  (res_word),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata)
  );

  // Byte store, bit 0 = MSB of byte 0
  bfpu_ram #(
    .Width (8),
    .Depth (STORE_BYTES)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Output register: engine takes the next word while a result waits
  bfpu_out_reg u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (res_valid),
    .res_ready_o (res_ready),
    .res_word_i  (res_word),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_word_o  (out_word_o)
  );

  // A flagged word never carries data
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid |-> (res_word.read_value == '0 || !res_word.range_error))
    else $error("range error with nonzero read value");

  // Engine never offers a result while taking a new word
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid |-> !in_ready_o)
    else $error("ready while result pending");

  // Accepted word leaves the engine busy next cycle
  a_leave_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("engine stayed ready after accept");

  // Handoff into the output register is captured intact
  a_handoff: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid && res_ready |=> out_valid_o && out_word_o == $past(res_word))
    else $error("result lost in output register");

endmodule

`default_nettype wire
